// File: rtl/pcpe_pkg.sv
// Shared types, constants and register map for the part-count period estimator.
package pcpe_pkg;

  // Milliseconds per second
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned MS_W     = 10;   // bits to hold MS_PER_S
  localparam int unsigned SEC_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PROD_W   = SEC_W + MS_W;

  // APB register map (byte address = 4 * index)
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIRST_DELAY = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTERVAL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_CYCLE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  // Estimation phase codes
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_SNAP    = 3'd2,
    PH_CHG1    = 3'd3,
    PH_CHG2    = 3'd4,
    PH_INVALID = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic             enable;
    logic [SEC_W-1:0] first_delay_s;
    logic [SEC_W-1:0] interval_s;
    logic [SEC_W-1:0] min_cycle_s;
    logic [SEC_W-1:0] timeout_s;
  } cfg_t;

endpackage

// File: rtl/pcpe_if.sv
// Valid/ready channel interfaces for tick words and result words.
interface pcpe_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        count_valid;
  logic [31:0] part_count;

  modport source (output valid, output now_ms, output count_valid, output part_count,
                  input ready);
  modport sink   (input valid, input now_ms, input count_valid, input part_count,
                  output ready);
endinterface

interface pcpe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cycle_time_ms;
  logic        estimate_valid;
  logic        busy_res;
  logic [2:0]  phase;
  logic        round_done;

  modport source (output valid, output cycle_time_ms, output estimate_valid,
                  output busy_res, output phase, output round_done, input ready);
  modport sink   (input valid, input cycle_time_ms, input estimate_valid,
                  input busy_res, input phase, input round_done, output ready);
endinterface

// File: rtl/pcpe_regs.sv
// APB configuration register file for the period estimator.
module pcpe_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcpe_pkg::ADDR_W-1:0] paddr,
  input  logic [pcpe_pkg::DATA_W-1:0] pwdata,
  output logic [pcpe_pkg::DATA_W-1:0] prdata,
  output pcpe_pkg::cfg_t              cfg
);

  logic                       wr_en;
  logic [pcpe_pkg::IDX_W-1:0] idx;

  assign idx   = paddr[pcpe_pkg::ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        pcpe_pkg::REG_ENABLE:      cfg.enable        <= pwdata[0];
        pcpe_pkg::REG_FIRST_DELAY: cfg.first_delay_s <= pwdata[pcpe_pkg::SEC_W-1:0];
        pcpe_pkg::REG_INTERVAL:    cfg.interval_s    <= pwdata[pcpe_pkg::SEC_W-1:0];
        pcpe_pkg::REG_MIN_CYCLE:   cfg.min_cycle_s   <= pwdata[pcpe_pkg::SEC_W-1:0];
        pcpe_pkg::REG_TIMEOUT:     cfg.timeout_s     <= pwdata[pcpe_pkg::SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (idx)
      pcpe_pkg::REG_ENABLE:      prdata = pcpe_pkg::DATA_W'(cfg.enable);
      pcpe_pkg::REG_FIRST_DELAY: prdata = pcpe_pkg::DATA_W'(cfg.first_delay_s);
      pcpe_pkg::REG_INTERVAL:    prdata = pcpe_pkg::DATA_W'(cfg.interval_s);
      pcpe_pkg::REG_MIN_CYCLE:   prdata = pcpe_pkg::DATA_W'(cfg.min_cycle_s);
      pcpe_pkg::REG_TIMEOUT:     prdata = pcpe_pkg::DATA_W'(cfg.timeout_s);
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: rtl/part_count_period_estimator_core.sv
// Top level of the part-count period estimator: tick register, phase logic, result register.
//
// Takes one tick word per clock while input ready is high and returns one result word per
// tick: the accepting edge loads the tick register, then the phase logic (one 16x10
// multiply, a 33-bit saturating add and 32-bit compares) runs on it and loads the result
// register and the estimator state when the result register can take a word. The next
// tick sees the state left by the previous one. Input ready falls only when both the tick
// register and the result register are full and the result is not taken. Configuration
// writes take effect from the next tick.
module part_count_period_estimator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcpe_pkg::ADDR_W-1:0] paddr,
  input  logic [pcpe_pkg::DATA_W-1:0] pwdata,
  output logic [pcpe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  pcpe_in_if.sink                     in_ch,
  pcpe_out_if.source                  out_ch
);

  pcpe_pkg::cfg_t cfg;

  // Tick register
  logic                        s1_valid;
  logic [pcpe_pkg::TIME_W-1:0] s1_now;
  logic                        s1_cvalid;
  logic [31:0]                 s1_count;
  logic                        advance;

  // Estimator state
  pcpe_pkg::phase_t            phase_reg, phase_reg_next;
  logic                        first_done, first_done_next;
  logic [pcpe_pkg::TIME_W-1:0] start_time, start_time_next;
  logic [pcpe_pkg::TIME_W-1:0] stop_time, stop_time_next;
  logic [31:0]                 count_snapshot, count_snapshot_next;
  logic [pcpe_pkg::TIME_W-1:0] mark_time, mark_time_next;
  logic [pcpe_pkg::TIME_W-1:0] cycle_time_reg, cycle_time_reg_next;
  logic                        valid_reg, valid_reg_next;
  logic                        busy_reg, busy_reg_next;
  logic                        done;

  // Arithmetic helpers
  logic [pcpe_pkg::SEC_W-1:0]  delay_s;
  logic [pcpe_pkg::PROD_W-1:0] delay_ms, min_ms, tmo_ms;
  logic [pcpe_pkg::TIME_W:0]   stop_sum;
  logic [pcpe_pkg::TIME_W-1:0] ct, elapsed;

  assign pready = 1'b1;

  pcpe_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  // Handshake: the phase step runs whenever the result register can take a word
  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_now    <= in_ch.now_ms;
      s1_cvalid <= in_ch.count_valid;
      s1_count  <= in_ch.part_count;
    end
  end

  // Seconds to milliseconds; stop time saturates at the top of the time range
  assign delay_s  = first_done ? cfg.interval_s : cfg.first_delay_s;
  assign delay_ms = pcpe_pkg::PROD_W'(delay_s) * pcpe_pkg::PROD_W'(pcpe_pkg::MS_PER_S);
  assign min_ms   = pcpe_pkg::PROD_W'(cfg.min_cycle_s) * pcpe_pkg::PROD_W'(pcpe_pkg::MS_PER_S);
  assign tmo_ms   = pcpe_pkg::PROD_W'(cfg.timeout_s) * pcpe_pkg::PROD_W'(pcpe_pkg::MS_PER_S);
  assign stop_sum = {1'b0, s1_now} + (pcpe_pkg::TIME_W+1)'(delay_ms);
  assign ct       = s1_now - mark_time;
  assign elapsed  = s1_now - start_time_next;

  // Phase step for the registered tick
  always_comb begin
    phase_reg_next      = phase_reg;
    first_done_next     = first_done;
    start_time_next     = start_time;
    stop_time_next      = stop_time;
    count_snapshot_next = count_snapshot;
    mark_time_next      = mark_time;
    cycle_time_reg_next = cycle_time_reg;
    valid_reg_next      = valid_reg;
    busy_reg_next       = busy_reg;
    done                = 1'b0;

    case (phase_reg)
      pcpe_pkg::PH_IDLE: begin
        if (cfg.enable) begin
          start_time_next = s1_now;
          first_done_next = 1'b1;
          stop_time_next  = stop_sum[pcpe_pkg::TIME_W] ? '1 : stop_sum[pcpe_pkg::TIME_W-1:0];
          phase_reg_next  = pcpe_pkg::PH_WAIT;
        end
      end
      pcpe_pkg::PH_WAIT: begin
        if (s1_now > stop_time) begin
          busy_reg_next  = 1'b1;
          phase_reg_next = pcpe_pkg::PH_SNAP;
        end
      end
      pcpe_pkg::PH_SNAP: begin
        if (!s1_cvalid) begin
          phase_reg_next = pcpe_pkg::PH_INVALID;
        end else begin
          count_snapshot_next = s1_count;
          phase_reg_next      = pcpe_pkg::PH_CHG1;
        end
      end
      pcpe_pkg::PH_CHG1: begin
        if (!s1_cvalid) begin
          phase_reg_next = pcpe_pkg::PH_INVALID;
        end else if (s1_count != count_snapshot) begin
          count_snapshot_next = s1_count;
          mark_time_next      = s1_now;
          phase_reg_next      = pcpe_pkg::PH_CHG2;
        end
      end
      pcpe_pkg::PH_CHG2: begin
        if (!s1_cvalid) begin
          phase_reg_next = pcpe_pkg::PH_INVALID;
        end else if (s1_count != count_snapshot) begin
          if (s1_now < mark_time) begin
            // time went backwards
            phase_reg_next = pcpe_pkg::PH_ERROR;
          end else begin
            if (ct > pcpe_pkg::TIME_W'(min_ms)) begin
              cycle_time_reg_next = ct;
              valid_reg_next      = 1'b1;
            end else begin
              valid_reg_next = 1'b0;
            end
            busy_reg_next  = 1'b0;
            phase_reg_next = pcpe_pkg::PH_IDLE;
            done           = 1'b1;
          end
        end
      end
      default: begin
        // invalid, error and the unused code all drop the round
        valid_reg_next = 1'b0;
        busy_reg_next  = 1'b0;
        phase_reg_next = pcpe_pkg::PH_IDLE;
      end
    endcase

    // Timeout wins over whatever the phase logic chose
    if (busy_reg_next && (s1_now > start_time_next)
        && (elapsed > pcpe_pkg::TIME_W'(tmo_ms))) begin
      phase_reg_next = pcpe_pkg::PH_ERROR;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= pcpe_pkg::PH_IDLE;
      first_done     <= 1'b0;
      start_time     <= '0;
      stop_time      <= '0;
      count_snapshot <= '0;
      mark_time      <= '0;
      cycle_time_reg <= '0;
      valid_reg      <= 1'b0;
      busy_reg       <= 1'b0;
      out_ch.valid   <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= s1_valid;
      if (s1_valid) begin
        phase_reg      <= phase_reg_next;
        first_done     <= first_done_next;
        start_time     <= start_time_next;
        stop_time      <= stop_time_next;
        count_snapshot <= count_snapshot_next;
        mark_time      <= mark_time_next;
        cycle_time_reg <= cycle_time_reg_next;
        valid_reg      <= valid_reg_next;
        busy_reg       <= busy_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_ch.cycle_time_ms  <= cycle_time_reg_next;
      out_ch.estimate_valid <= valid_reg_next;
      out_ch.busy_res       <= busy_reg_next;
      out_ch.phase          <= phase_reg_next;
      out_ch.round_done     <= done;
    end
  end

endmodule

// File: rtl/pcpe_checker.sv
// Port-level checks for the period estimator, bound to the top level.
module pcpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] cycle_time_ms,
  input logic        estimate_valid,
  input logic        busy_res,
  input logic [2:0]  phase,
  input logic        round_done
);

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cycle_time_ms) && $stable(phase))
    else $error("result word changed while stalled");

  // A finished round always lands back in idle, not busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && round_done |-> phase == pcpe_pkg::PH_IDLE && !busy_res)
    else $error("round finished outside idle");

  // An accepted estimate is strictly positive
  a_est_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && round_done && estimate_valid |-> cycle_time_ms != '0)
    else $error("accepted cycle time of zero");

  // Busy exactly in the measuring, invalid and error phases
  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy_res == (phase != pcpe_pkg::PH_IDLE && phase != pcpe_pkg::PH_WAIT))
    else $error("busy flag disagrees with phase");

  // No result word on the first edge after reset is released
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result word present after reset");

endmodule

bind part_count_period_estimator_core pcpe_checker u_pcpe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cycle_time_ms (out_ch.cycle_time_ms),
  .estimate_valid(out_ch.estimate_valid),
  .busy_res      (out_ch.busy_res),
  .phase         (out_ch.phase),
  .round_done    (out_ch.round_done)
);

// File: tb/part_count_period_estimator_core_test.sv
// Self-checking testbench for the part-count period estimator core.
module part_count_period_estimator_core_test;
  import pcpe_pkg::*;

  // One result word as the core should present it
  typedef struct {
    logic [TIME_W-1:0] cycle_time_ms;
    logic              estimate_valid;
    logic              busy_res;
    logic [2:0]        phase;
    logic              round_done;
  } result_word_t;

  // Index past the end of the register map, writes there are dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int unsigned REG_COUNT = 5;
  localparam logic [SEC_W-1:0] SEC_MAX = 16'hFFFF;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pcpe_in_if  tick_ch ();
  pcpe_out_if res_ch ();

  part_count_period_estimator_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (tick_ch),
    .out_ch  (res_ch)
  );

  // Expected result words, oldest first
  result_word_t expected_q[$];
  int mismatches = 0;

  // Idling controls
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  int hold_left  = 0;
  int stall_left = 0;

  // Stimulus time base and counter base
  logic [31:0] sim_ms;
  logic [31:0] part_base;

  // Predictor copy of configuration and estimator state
  logic             cfg_enable;
  logic [SEC_W-1:0] cfg_first_delay;
  logic [SEC_W-1:0] cfg_interval;
  logic [SEC_W-1:0] cfg_min_cycle;
  logic [SEC_W-1:0] cfg_timeout;
  phase_t           est_phase;
  logic             est_first_done;
  logic             est_valid;
  logic             est_busy;
  logic [31:0]      est_start;
  logic [31:0]      est_stop;
  logic [31:0]      est_snap;
  logic [31:0]      est_mark;
  logic [31:0]      est_cycle;

  // Clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Safety net against a hung run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] deadline_ms(input logic [31:0] base,
                                              input logic [SEC_W-1:0] secs);
    logic [63:0] sum;
    sum = 64'(base) + 64'(secs) * 64'(MS_PER_S);
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic exceeds_s(input logic [31:0] ms, input logic [SEC_W-1:0] secs);
    return 64'(ms) > 64'(secs) * 64'(MS_PER_S);
  endfunction

  // Advance the predicted estimator by one tick and return its result word
  function automatic result_word_t predict_tick(input logic [31:0] now, input logic cv,
                                                input logic [31:0] cnt);
    result_word_t r;
    logic         done;
    logic [31:0]  ct;
    done = 1'b0;
    case (est_phase)
      PH_IDLE: begin
        if (cfg_enable) begin
          est_start = now;
          if (!est_first_done) begin
            est_first_done = 1'b1;
            est_stop = deadline_ms(now, cfg_first_delay);
          end else begin
            est_stop = deadline_ms(now, cfg_interval);
          end
          est_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (now > est_stop) begin
          est_busy  = 1'b1;
          est_phase = PH_SNAP;
        end
      end
      PH_SNAP: begin
        if (!cv) begin
          est_phase = PH_INVALID;
        end else begin
          est_snap  = cnt;
          est_phase = PH_CHG1;
        end
      end
      PH_CHG1: begin
        if (!cv) begin
          est_phase = PH_INVALID;
        end else if (cnt != est_snap) begin
          est_snap  = cnt;
          est_mark  = now;
          est_phase = PH_CHG2;
        end
      end
      PH_CHG2: begin
        if (!cv) begin
          est_phase = PH_INVALID;
        end else if (cnt != est_snap) begin
          if (now < est_mark) begin
            est_phase = PH_ERROR;
          end else begin
            ct = now - est_mark;
            if (exceeds_s(ct, cfg_min_cycle)) begin
              est_cycle = ct;
              est_valid = 1'b1;
            end else begin
              est_valid = 1'b0;
            end
            est_busy  = 1'b0;
            est_phase = PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      default: begin
        est_valid = 1'b0;
        est_busy  = 1'b0;
        est_phase = PH_IDLE;
      end
    endcase
    // timeout wins over whatever the phase logic chose
    if (est_busy && now > est_start && exceeds_s(now - est_start, cfg_timeout))
      est_phase = PH_ERROR;
    r.cycle_time_ms  = est_cycle;
    r.estimate_valid = est_valid;
    r.busy_res       = est_busy;
    r.phase          = est_phase;
    r.round_done     = done;
    return r;
  endfunction

  function automatic void cfg_store(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    case (idx)
      REG_ENABLE:      cfg_enable      = value[0];
      REG_FIRST_DELAY: cfg_first_delay = value[SEC_W-1:0];
      REG_INTERVAL:    cfg_interval    = value[SEC_W-1:0];
      REG_MIN_CYCLE:   cfg_min_cycle   = value[SEC_W-1:0];
      REG_TIMEOUT:     cfg_timeout     = value[SEC_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] cfg_value(input logic [IDX_W-1:0] idx);
    case (idx)
      REG_ENABLE:      return 32'(cfg_enable);
      REG_FIRST_DELAY: return 32'(cfg_first_delay);
      REG_INTERVAL:    return 32'(cfg_interval);
      REG_MIN_CYCLE:   return 32'(cfg_min_cycle);
      REG_TIMEOUT:     return 32'(cfg_timeout);
      default:         return 32'h0;
    endcase
  endfunction

  // Random junk in the bits a register does not keep
  function automatic logic [31:0] junk_bits(input logic [31:0] unused_mask);
    if ($urandom_range(0, 3) == 0) return $urandom & unused_mask;
    return 32'h0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_cycle(input logic write, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== cfg_value(idx))
      report_mismatch($sformatf("register %0d read: expected %h, got %h",
                                idx, cfg_value(idx), rd));
  endtask

  task automatic apb_config(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    logic [DATA_W-1:0] rd;
    apb_cycle(1'b1, idx, value, rd);
    cfg_store(idx, value);
    if (idx < REG_COUNT) check_register(idx);
  endtask

  // Offer one tick word, wait for it to be taken, record what it should produce
  task automatic send_tick(input logic [31:0] now, input logic cv, input logic [31:0] cnt);
    int gap;
    @(negedge clk);
    tick_ch.now_ms      <= now;
    tick_ch.count_valid <= cv;
    tick_ch.part_count  <= cnt;
    tick_ch.valid       <= 1'b1;
    do @(posedge clk); while (!tick_ch.ready);
    expected_q.push_back(predict_tick(now, cv, cnt));
    if (tx_gaps_on && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      tick_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, let every expected word arrive, then allow for the pipeline
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly plausible ticks steered by the predicted phase, some noise
  task automatic random_tick();
    logic [31:0] now;
    logic [31:0] cnt;
    logic        cv;
    int          roll;
    roll = $urandom_range(0, 99);
    if (est_phase == PH_IDLE && sim_ms > 32'h8000_0000)
      sim_ms = $urandom_range(0, 5000);
    if (est_phase == PH_WAIT && $urandom_range(0, 3) == 0)
      sim_ms = est_stop + $urandom_range(0, 1);
    else if (roll >= 95)
      sim_ms = sim_ms + $urandom_range(5000, 30000);
    else
      sim_ms = sim_ms + $urandom_range(0, 1500);
    if ($urandom_range(0, 2) == 0)
      part_base = ($urandom_range(0, 9) == 0) ? $urandom : part_base + 1;
    now = sim_ms;
    cv  = 1'b1;
    cnt = part_base;
    if (roll < 5) begin
      cv = 1'b0;
    end else if (roll < 9) begin
      if (sim_ms > 3000) now = sim_ms - $urandom_range(1, 3000);
    end else if (roll < 12) begin
      // arbitrary time only where it cannot open a round that never ends
      if (est_phase != PH_IDLE) now = $urandom;
    end else if (roll < 15) begin
      cnt = $urandom;
      cv  = $urandom_range(0, 1);
    end
    send_tick(now, cv, cnt);
  endtask

  // Result checker: each taken word against the oldest expectation
  always @(posedge clk) begin : result_check
    result_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: ct=%h v=%b b=%b ph=%0d d=%b",
                                  res_ch.cycle_time_ms, res_ch.estimate_valid,
                                  res_ch.busy_res, res_ch.phase, res_ch.round_done));
      end else begin
        want = expected_q.pop_front();
        if (res_ch.cycle_time_ms !== want.cycle_time_ms ||
            res_ch.estimate_valid !== want.estimate_valid ||
            res_ch.busy_res !== want.busy_res ||
            res_ch.phase !== want.phase ||
            res_ch.round_done !== want.round_done)
          report_mismatch($sformatf(
            "result mismatch: expected ct=%h v=%b b=%b ph=%0d d=%b, got ct=%h v=%b b=%b ph=%0d d=%b",
            want.cycle_time_ms, want.estimate_valid, want.busy_res, want.phase,
            want.round_done, res_ch.cycle_time_ms, res_ch.estimate_valid,
            res_ch.busy_res, res_ch.phase, res_ch.round_done));
      end
    end
  end

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (rx_gaps_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Register map: masking of unused bits, write past the map, read-back
  task automatic test_register_map();
    apb_config(REG_FIRST_DELAY, 32'hABCD_0000);
    apb_config(REG_INTERVAL, 32'h1234_FFFF);
    apb_config(REG_MIN_CYCLE, 32'hFFFF_0003);
    apb_config(REG_TIMEOUT, 32'h8000_0001);
    apb_config(REG_ENABLE, 32'hFFFF_FFFE);
    apb_config(REG_SPARE, 32'hFFFF_FFFF);
    for (int i = 0; i < REG_COUNT; i++) check_register(IDX_W'(i));
  endtask

  // Disabled block stays idle, field extremes
  task automatic test_idle_ticks();
    send_tick(32'h0, 1'b0, 32'h0);
    send_tick(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
  endtask

  // A clean first round, cycle accepted
  task automatic test_first_round();
    settle();
    apb_config(REG_FIRST_DELAY, 32'h0);
    apb_config(REG_INTERVAL, 32'h0);
    apb_config(REG_MIN_CYCLE, 32'h0);
    apb_config(REG_TIMEOUT, 32'(SEC_MAX));
    apb_config(REG_ENABLE, 32'h1);
    send_tick(32'd100, 1'b0, 32'd0);
    send_tick(32'd101, 1'b1, 32'd0);
    send_tick(32'd102, 1'b1, 32'd5);
    send_tick(32'd103, 1'b1, 32'd5);
    send_tick(32'd110, 1'b1, 32'd6);
    send_tick(32'd2110, 1'b1, 32'd7);
  endtask

  // Cycle exactly at the minimum is rejected
  task automatic test_boundary_reject();
    settle();
    apb_config(REG_MIN_CYCLE, 32'd2);
    send_tick(32'd3000, 1'b1, 32'd9);
    send_tick(32'd3001, 1'b1, 32'd9);
    send_tick(32'd3002, 1'b1, 32'd7);
    send_tick(32'd3003, 1'b1, 32'd8);
    send_tick(32'd5003, 1'b1, 32'd9);
  endtask

  // Invalid counter reading during the snapshot
  task automatic test_invalid_counter();
    send_tick(32'd6000, 1'b1, 32'd1);
    send_tick(32'd6001, 1'b1, 32'd1);
    send_tick(32'd6002, 1'b0, 32'd1);
    send_tick(32'd6003, 1'b1, 32'd1);
  endtask

  // Second change seen with time before the mark
  task automatic test_time_backwards();
    send_tick(32'd7000, 1'b1, 32'd0);
    send_tick(32'd7001, 1'b1, 32'd0);
    send_tick(32'd7002, 1'b1, 32'd1);
    send_tick(32'd7003, 1'b1, 32'd2);
    send_tick(32'd7002, 1'b1, 32'd3);
    send_tick(32'd7004, 1'b1, 32'd3);
  endtask

  // Random rounds over a spread of settings, extremes included
  task automatic test_random_rounds();
    logic [SEC_W-1:0] first;
    logic [SEC_W-1:0] gap_s;
    logic [SEC_W-1:0] min_s;
    logic [SEC_W-1:0] tmo_s;
    sim_ms    = 32'd10000;
    part_base = 32'd100;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      first = (ph == 1) ? SEC_MAX : (ph == 2) ? '0 : SEC_W'($urandom_range(0, 5));
      gap_s = (ph == 3) ? SEC_MAX : SEC_W'($urandom_range(0, 3));
      min_s = (ph == 0) ? '0 : (ph == 6) ? SEC_MAX : SEC_W'($urandom_range(0, 3));
      tmo_s = (ph == 2) ? '0 : (ph == 4) ? SEC_MAX : SEC_W'($urandom_range(1, 20));
      apb_config(REG_FIRST_DELAY, 32'(first) | junk_bits(32'hFFFF_0000));
      apb_config(REG_INTERVAL, 32'(gap_s) | junk_bits(32'hFFFF_0000));
      apb_config(REG_MIN_CYCLE, 32'(min_s) | junk_bits(32'hFFFF_0000));
      apb_config(REG_TIMEOUT, 32'(tmo_s) | junk_bits(32'hFFFF_0000));
      apb_config(REG_ENABLE, ((ph == 5) ? 32'h0 : 32'h1) | junk_bits(32'hFFFF_FFFE));
      tx_gaps_on = (ph % 3 != 1);
      rx_gaps_on = (ph % 4 != 2);
      repeat (190) random_tick();
    end
  endtask

  // Receiver holds off while ticks keep coming, so the core fills and stalls
  task automatic test_output_stall();
    settle();
    apb_config(REG_INTERVAL, 32'd1);
    apb_config(REG_MIN_CYCLE, 32'd1);
    apb_config(REG_TIMEOUT, 32'd30);
    apb_config(REG_ENABLE, 32'h1);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    hold_left  = 300;
    repeat (60) random_tick();
    tx_gaps_on = 1'b1;
  endtask

  // Stop time saturates, the wait never ends; left for last
  task automatic test_saturated_wait();
    settle();
    apb_config(REG_TIMEOUT, 32'(SEC_MAX));
    apb_config(REG_INTERVAL, 32'(SEC_MAX));
    apb_config(REG_ENABLE, 32'h1);
    while (est_phase != PH_IDLE) begin
      if (est_phase == PH_WAIT) send_tick(est_stop + 1, 1'b1, part_base);
      else send_tick(sim_ms, 1'b0, part_base);
    end
    send_tick(32'hFFFF_0000, 1'b1, part_base);
    send_tick(32'hFFFF_FFFF, 1'b1, part_base + 1);
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.now_ms      = '0;
    tick_ch.count_valid = 1'b0;
    tick_ch.part_count  = '0;
    res_ch.ready        = 1'b0;
    sim_ms              = '0;
    part_base           = '0;
    cfg_enable          = 1'b0;
    cfg_first_delay     = '0;
    cfg_interval        = '0;
    cfg_min_cycle       = '0;
    cfg_timeout         = '0;
    est_phase           = PH_IDLE;
    est_first_done      = 1'b0;
    est_valid           = 1'b0;
    est_busy            = 1'b0;
    est_start           = '0;
    est_stop            = '0;
    est_snap            = '0;
    est_mark            = '0;
    est_cycle           = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_register_map();
    test_idle_ticks();
    test_first_round();
    test_boundary_reject();
    test_invalid_counter();
    test_time_backwards();
    test_random_rounds();
    test_output_stall();
    test_saturated_wait();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
